// File: rtl/ramd_pkg.sv
package ramd_pkg;

   localparam int MAX_PIXELS  = 2097152;
   localparam int IDX_W       = $clog2(MAX_PIXELS);
   localparam int FRAME_W     = 22;
   localparam int BG_W        = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 22;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_Q16    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RENDER_MODE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PIXELS = 2'd3;

   // render modes; the unused code renders as the overlay
   localparam logic [1:0] RENDER_OVERLAY = 2'd0;
   localparam logic [1:0] RENDER_MASK    = 2'd1;
   localparam logic [1:0] RENDER_DIFF    = 2'd2;

   localparam logic [6:0]         SENS_RESET   = 7'd75;
   localparam logic [15:0]        DECAY_RESET  = 16'd3277;
   localparam logic [1:0]         MODE_RESET   = RENDER_OVERLAY;
   localparam logic [FRAME_W-1:0] FRAME_RESET  = 22'd307200;
   localparam logic [8:0]         THRESH_BASE  = 9'd101;

   typedef struct packed {
      logic [6:0]         sensitivity;
      logic [15:0]        decay_q16;
      logic [1:0]         render_mode;
      logic [FRAME_W-1:0] frame_pixels;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] pixel_index;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic             last_of_frame;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       moving;
   } rsp_type;

   // classified pixel handed from front to back
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic [7:0]       luma;
      logic             in_range;
      logic             seeded;
   } work_type;

   function automatic logic [7:0] luma_of(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r);
      logic [22:0] sum;
      sum = 23'(b) * 23'd1868 + 23'(g) * 23'd9617 + 23'(r) * 23'd4899 + 23'd8192;
      return sum[21:14];
   endfunction

   // (11*c + 9*t + 10) / 20 with t either 0 or 255; divide by reciprocal
   function automatic logic [7:0] blend_chan(input logic [7:0] c, input logic to_red);
      logic [12:0] x;
      logic [28:0] q;
      x = 13'(c) * 13'd11 + (to_red ? 13'd2295 : 13'd0) + 13'd10;
      q = 29'(x) * 29'd52429;
      return q[27:20];
   endfunction

endpackage

// File: rtl/ramd_front.sv
module ramd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  ramd_pkg::req_type        req,
   output logic                     req_stall,
   input  logic [ramd_pkg::FRAME_W-1:0] frame_pixels,
   input  logic                     clear_model,
   input  logic                     q_full,
   output logic                     push,
   output ramd_pkg::work_type       push_data
);
   import ramd_pkg::*;

   logic model_valid_ff, model_valid_in;
   logic accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign push      = accept;

   always_comb begin
      push_data.idx      = req.pixel_index;
      push_data.blue     = req.blue;
      push_data.green    = req.green;
      push_data.red      = req.red;
      push_data.luma     = luma_of(req.blue, req.green, req.red);
      push_data.in_range = {1'b0, req.pixel_index} < frame_pixels;
      push_data.seeded   = model_valid_ff;
   end

   always_comb begin
      model_valid_in = model_valid_ff;
      if (clear_model) begin
         model_valid_in = 1'b0;
      end else if (accept && req.last_of_frame) begin
         model_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         model_valid_ff <= 1'b0;
      end else begin
         model_valid_ff <= model_valid_in;
      end
   end

endmodule

// File: rtl/ramd_queue.sv
module ramd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ramd_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output ramd_pkg::work_type head
);
   import ramd_pkg::*;

   work_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/ramd_back.sv
module ramd_back (
   input  logic               clock,
   input  logic               reset,
   input  ramd_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  ramd_pkg::work_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   output ramd_pkg::rsp_type  rsp,
   input  logic               rsp_stall
);
   import ramd_pkg::*;

   typedef struct packed {
      work_type    w;
      logic [BG_W-1:0] bg;
      logic [39:0] prod;
      logic [23:0] yd;
      logic [7:0]  diff;
      logic        moving;
      logic [7:0]  bl_blue;
      logic [7:0]  bl_green;
      logic [7:0]  bl_red;
   } p2_type;

   logic [BG_W-1:0] bg_mem [MAX_PIXELS];
   logic [BG_W-1:0] rd_ff;

   logic     p1_v_ff, p1_v_in;
   work_type p1_ff;
   logic     p2_v_ff, p2_v_in;
   p2_type   p2_ff, p2_in;
   logic     out_v_ff, out_v_in;
   rsp_type  out_ff, out_in;

   // last two background writes, newest in slot 0
   logic             hist_v_ff   [2];
   logic [IDX_W-1:0] hist_idx_ff [2];
   logic [BG_W-1:0]  hist_bg_ff  [2];

   logic            out_free, p2_ready, hazard, p1_move, p1_ready, wr_en;
   logic [BG_W-1:0] bg_sel, wr_val, learned;
   logic [24:0]     ref_sum;
   logic [7:0]      ref8, diff;
   logic [8:0]      score;
   logic [40:0]     ceil_sum;
   logic [26:0]     nb;

   assign out_free = !out_v_ff || !rsp_stall;
   assign p2_ready = !p2_v_ff || out_free;
   // a reading pixel right behind a write to the same entry waits until that write is done
   assign hazard   = p1_v_ff && p1_ff.in_range && p1_ff.seeded && p2_v_ff
                     && p2_ff.w.in_range && (p2_ff.w.idx == p1_ff.idx);
   assign p1_move  = p1_v_ff && p2_ready && !hazard;
   assign p1_ready = !p1_v_ff || p1_move;
   assign q_pop    = q_valid && p1_ready;
   assign wr_en    = p2_v_ff && out_free && p2_ff.w.in_range;

   // stage 1: pick freshest background, compare, multiply, blend
   always_comb begin
      if (hist_v_ff[0] && hist_idx_ff[0] == p1_ff.idx) begin
         bg_sel = hist_bg_ff[0];
      end else if (hist_v_ff[1] && hist_idx_ff[1] == p1_ff.idx) begin
         bg_sel = hist_bg_ff[1];
      end else begin
         bg_sel = rd_ff;
      end
      ref_sum = {1'b0, bg_sel} + 25'h8000;
      ref8    = ref_sum[24] ? 8'hFF : ref_sum[23:16];
      diff    = (p1_ff.luma > ref8) ? p1_ff.luma - ref8 : ref8 - p1_ff.luma;
      score   = {1'b0, diff} + {2'b0, cfg.sensitivity};

      p2_in.w        = p1_ff;
      p2_in.bg       = bg_sel;
      p2_in.prod     = 40'(bg_sel) * 40'(cfg.decay_q16);
      p2_in.yd       = 24'(p1_ff.luma) * 24'(cfg.decay_q16);
      p2_in.diff     = diff;
      p2_in.moving   = p1_ff.in_range && p1_ff.seeded && (score > THRESH_BASE);
      p2_in.bl_blue  = blend_chan(p1_ff.blue, 1'b0);
      p2_in.bl_green = blend_chan(p1_ff.green, 1'b0);
      p2_in.bl_red   = blend_chan(p1_ff.red, 1'b1);
   end

   // stage 2: learn, write back, render
   always_comb begin
      ceil_sum = {1'b0, p2_ff.prod} + 41'hFFFF;
      nb = {3'b0, p2_ff.bg} + {3'b0, p2_ff.yd} - {2'b0, ceil_sum[40:16]};
      if (nb[26]) begin
         learned = '0;
      end else if (nb[25:24] != 2'b0) begin
         learned = '1;
      end else begin
         learned = nb[23:0];
      end
      wr_val = p2_ff.w.seeded ? learned : {p2_ff.w.luma, 16'h0};

      out_in.out_blue  = p2_ff.w.blue;
      out_in.out_green = p2_ff.w.green;
      out_in.out_red   = p2_ff.w.red;
      out_in.moving    = p2_ff.moving;
      if (p2_ff.w.in_range && p2_ff.w.seeded) begin
         case (cfg.render_mode)
            RENDER_MASK: begin
               out_in.out_blue  = p2_ff.moving ? 8'hFF : 8'h00;
               out_in.out_green = p2_ff.moving ? 8'hFF : 8'h00;
               out_in.out_red   = p2_ff.moving ? 8'hFF : 8'h00;
            end
            RENDER_DIFF: begin
               out_in.out_blue  = p2_ff.diff;
               out_in.out_green = p2_ff.diff;
               out_in.out_red   = p2_ff.diff;
            end
            default: begin
               if (p2_ff.moving) begin
                  out_in.out_blue  = p2_ff.bl_blue;
                  out_in.out_green = p2_ff.bl_green;
                  out_in.out_red   = p2_ff.bl_red;
               end
            end
         endcase
      end
   end

   always_comb begin
      p1_v_in = p1_v_ff;
      if (q_pop) begin
         p1_v_in = 1'b1;
      end else if (p1_move) begin
         p1_v_in = 1'b0;
      end
      p2_v_in = p2_v_ff;
      if (p1_move) begin
         p2_v_in = 1'b1;
      end else if (out_free) begin
         p2_v_in = 1'b0;
      end
      out_v_in = out_free ? p2_v_ff : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         out_v_ff     <= 1'b0;
         hist_v_ff[0] <= 1'b0;
         hist_v_ff[1] <= 1'b0;
      end else begin
         p1_v_ff  <= p1_v_in;
         p2_v_ff  <= p2_v_in;
         out_v_ff <= out_v_in;
         if (wr_en) begin
            hist_v_ff[0] <= 1'b1;
            hist_v_ff[1] <= hist_v_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         p1_ff <= q_head;
      end
      if (p1_move) begin
         p2_ff <= p2_in;
      end
      if (out_free && p2_v_ff) begin
         out_ff <= out_in;
      end
      if (wr_en) begin
         hist_idx_ff[0] <= p2_ff.w.idx;
         hist_bg_ff[0]  <= wr_val;
         hist_idx_ff[1] <= hist_idx_ff[0];
         hist_bg_ff[1]  <= hist_bg_ff[0];
      end
   end

   // background memory: one read, one write port
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= bg_mem[q_head.idx];
      end
      if (wr_en) begin
         bg_mem[p2_ff.w.idx] <= wr_val;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp       = out_ff;

endmodule

// File: rtl/running_average_motion_detector.sv
// Running-average motion detector for a BGR pixel stream.
// req: one pixel per beat with its raster index and an end-of-frame flag.
// rsp: one rendered pixel per request beat, in order, with a moving flag.
// csr: write-only registers (sensitivity, decay, render mode, frame size);
//    csr_ready is always high; write only while no pixel is in flight.
//    Writing the frame size unseeds the background model.
// Pipeline: an accepted pixel is written into the queue, then registered by
// the queue pop with memory read, by compare and multiply, and by learn into
// the output register, from which it is offered on rsp.
// Throughput: one pixel per cycle while rsp_stall stays low. A seeded pixel
// whose index matches the pixel one stage ahead of it waits on the background
// read-modify-write.
// Reset empties the pipeline and unseeds the model; the background memory
// is not cleared. The first frame after reset or a frame-size write seeds it
// and passes through. rsp_stall holds the output beat; the four-entry queue
// keeps taking pixels until it fills, then req_stall rises.
module running_average_motion_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  ramd_pkg::req_type                  req,
   output logic                               req_stall,
   output logic                               rsp_valid,
   output ramd_pkg::rsp_type                  rsp,
   input  logic                               rsp_stall,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ramd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ramd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ramd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     csr_wr, clear_model;
   logic     q_full, q_push, q_pop, q_not_empty;
   work_type q_push_data, q_head;

   assign csr_ready   = 1'b1;
   assign csr_wr      = csr_valid && csr_ready;
   assign clear_model = csr_wr && (csr_index == CSR_FRAME_PIXELS);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_SENSITIVITY:  cfg_in.sensitivity  = csr_wdata[6:0];
            CSR_DECAY_Q16:    cfg_in.decay_q16    = csr_wdata[15:0];
            CSR_RENDER_MODE:  cfg_in.render_mode  = csr_wdata[1:0];
            CSR_FRAME_PIXELS: cfg_in.frame_pixels = csr_wdata[FRAME_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensitivity  <= SENS_RESET;
         cfg_ff.decay_q16    <= DECAY_RESET;
         cfg_ff.render_mode  <= MODE_RESET;
         cfg_ff.frame_pixels <= FRAME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ramd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req          (req),
      .req_stall    (req_stall),
      .frame_pixels (cfg_ff.frame_pixels),
      .clear_model  (clear_model),
      .q_full       (q_full),
      .push         (q_push),
      .push_data    (q_push_data)
   );

   ramd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   ramd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_not_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   a_mask_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.moving && cfg_ff.render_mode == RENDER_MASK
      |-> rsp.out_blue == 8'hFF && rsp.out_green == 8'hFF && rsp.out_red == 8'hFF)
      else $error("moving pixel in mask mode is not white");

   a_diff_over_thresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.moving && cfg_ff.render_mode == RENDER_DIFF
      |-> ({1'b0, rsp.out_red} + {2'b0, cfg_ff.sensitivity}) > THRESH_BASE)
      else $error("moving pixel below threshold in diff mode");

   a_queue_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !q_pop || q_not_empty)
      else $error("pop from empty queue");

endmodule
